>>> rtl/md5m_pkg.sv
// md5m_pkg: shared types, step constants and step functions for the md5 matcher
// no dependencies; imported by md5m_cell, md5m_rev and the top level
`timescale 1ns / 1ps
`default_nettype none
package md5m_pkg;

  localparam int NUM_STEPS = 48;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_TEST = 1'b1
  } cmd_t;

  // four-word sliding window, q0 oldest, q3 newest
  typedef struct packed {
    logic [31:0] q0;
    logic [31:0] q1;
    logic [31:0] q2;
    logic [31:0] q3;
  } win_t;

  typedef struct packed {
    win_t        win;
    logic [31:0] w0;
  } stage_t;

  typedef struct packed {
    logic        busy;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } check_t;

  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;

  localparam logic [31:0] K_TBL [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam logic [4:0] S_TBL [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  function automatic logic [4:0] step_shift(input logic [5:0] t);
    return S_TBL[{t[5:4], t[1:0]}];
  endfunction

  function automatic logic [3:0] msg_idx(input logic [5:0] t);
    logic [7:0] tt;
    tt = {2'b00, t};
    case (t[5:4])
      2'd0:    return t[3:0];
      2'd1:    return 4'((8'd5 * tt) + 8'd1);
      2'd2:    return 4'((8'd3 * tt) + 8'd5);
      default: return 4'(8'd7 * tt);
    endcase
  endfunction

  function automatic logic [31:0] msg_word(input logic [3:0] idx, input logic [31:0] w0,
                                           input logic [31:0] w1, input logic [31:0] w2,
                                           input logic [3:0] len);
    case (idx)
      4'd0:    return w0;
      4'd1:    return w1;
      4'd2:    return w2;
      4'd14:   return {25'd0, len, 3'b000};
      default: return 32'd0;
    endcase
  endfunction

  function automatic logic [31:0] round_f(input logic [5:0] t, input logic [31:0] x,
                                          input logic [31:0] y, input logic [31:0] z);
    case (t[5:4])
      2'd0:    return (x & y) | (~x & z);
      2'd1:    return (x & z) | (y & ~z);
      2'd2:    return x ^ y ^ z;
      default: return y ^ (x | ~z);
    endcase
  endfunction

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] s);
    logic [63:0] dbl;
    dbl = {x, x} << s;
    return dbl[63:32];
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input logic [4:0] s);
    logic [63:0] dbl;
    dbl = {x, x} >> s;
    return dbl[31:0];
  endfunction

endpackage
`default_nettype wire

>>> rtl/md5_reversed_step_matcher_core.sv
// md5_reversed_step_matcher_core: md5 candidate matcher, top level
// depends on md5m_pkg, md5m_cell (forward chain) and md5m_rev (reverse unit)
//
//  channel | handshake           | payload
//  in      | in_valid/in_ready   | in_command, in_word0, in_word1, in_word2, in_length_bytes
//  out     | out_valid/out_ready | out_found, out_early_hit
//  cfg     | cfg_we              | cfg_index, cfg_data
//
// test requests flow through a chain of 48 step cells, one request per cycle while the chain
// is not held, then through the compare/output register
// a load request waits until the chain is empty, then the reverse unit undoes steps
// 64 down to 49, one undone step a cycle, during which no request is taken
// the whole chain holds while a result waits on out_ready
// synchronous active-low reset clears valids, check words and stored words
`timescale 1ns / 1ps
`default_nettype none
module md5_reversed_step_matcher_core import md5m_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_command,
  input  wire logic [31:0] in_word0,
  input  wire logic [31:0] in_word1,
  input  wire logic [31:0] in_word2,
  input  wire logic [3:0]  in_length_bytes,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_found,
  output logic             out_early_hit,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  // target digest registers
  logic [31:0] tgt_r [4];

  // stored message suffix
  logic [31:0] word1_r, word2_r;
  logic [3:0]  len_r;

  logic        adv;
  logic        pipe_any;
  logic        acc;
  logic        load_acc;
  check_t      chk;

  logic        vld [NUM_STEPS+1];
  stage_t      stg [NUM_STEPS+1];

  logic        out_valid_r, out_found_r, out_early_r;
  logic        early;
  win_t        fin;

  // chain moves whenever the output register is free or being drained
  assign adv = !out_valid_r || out_ready;

  always_comb begin
    pipe_any = 1'b0;
    for (int i = 1; i <= NUM_STEPS; i++) begin
      pipe_any = pipe_any | vld[i];
    end
  end

  // a load only enters an empty chain so in-flight tests keep the old suffix
  assign in_ready = adv && !chk.busy && (in_command == CMD_TEST || !pipe_any);
  assign acc      = in_valid && in_ready;
  assign load_acc = acc && (in_command == CMD_LOAD);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        tgt_r[i] <= 32'd0;
      end
    end else if (cfg_we) begin
      tgt_r[cfg_index] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word1_r <= 32'd0;
      word2_r <= 32'd0;
      len_r   <= 4'd0;
    end else if (load_acc) begin
      word1_r <= in_word1;
      word2_r <= in_word2;
      len_r   <= in_length_bytes;
    end
  end

  md5m_rev u_rev (
    .clk   (clk),
    .rst_n (rst_n),
    .start (load_acc),
    .tgt_a (tgt_r[0]),
    .tgt_b (tgt_r[1]),
    .tgt_c (tgt_r[2]),
    .tgt_d (tgt_r[3]),
    .word1 (word1_r),
    .word2 (word2_r),
    .len   (len_r),
    .chk   (chk)
  );

  // chain head: iv in register order a, d, c, b
  assign vld[0] = acc && (in_command == CMD_TEST);
  assign stg[0] = '{win: '{q0: IV_A, q1: IV_D, q2: IV_C, q3: IV_B}, w0: in_word0};

  for (genvar g = 0; g < NUM_STEPS; g++) begin : g_cell
    md5m_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (adv),
      .step_idx (6'(g)),
      .vld_in   (vld[g]),
      .stg_in   (stg[g]),
      .word1    (word1_r),
      .word2    (word2_r),
      .len      (len_r),
      .vld_out  (vld[g+1]),
      .stg_out  (stg[g+1])
    );
  end

  // after step 48 the window is q48..q51: q48 is the step-45 register
  always_comb begin
    fin   = stg[NUM_STEPS].win;
    early = (fin.q0 + stg[NUM_STEPS].w0) == chk.a;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vld[NUM_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_early_r <= early;
      out_found_r <= early && (fin.q3 == chk.b) && (fin.q2 == chk.c) && (fin.q1 == chk.d);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_found     = out_found_r;
  assign out_early_hit = out_early_r;

  a_load_empty: assert property (@(posedge clk) disable iff (!rst_n)
    load_acc |-> !pipe_any)
    else $error("load taken with tests in flight");

  a_busy_block: assert property (@(posedge clk) disable iff (!rst_n)
    chk.busy |-> !acc)
    else $error("request taken while reversing");

  a_found_early: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_found && !out_early_hit))
    else $error("found without early hit");

endmodule
`default_nettype wire

>>> rtl/md5m_cell.sv
// md5m_cell: one registered forward md5 step of the candidate chain
// depends on md5m_pkg
`timescale 1ns / 1ps
`default_nettype none
module md5m_cell import md5m_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        en,
  input  wire logic [5:0]  step_idx,
  input  wire logic        vld_in,
  input  wire stage_t      stg_in,
  input  wire logic [31:0] word1,
  input  wire logic [31:0] word2,
  input  wire logic [3:0]  len,
  output logic             vld_out,
  output stage_t           stg_out
);

  logic        vld_r;
  stage_t      stg_r;
  stage_t      stg_nxt;
  logic [31:0] sum;
  logic [31:0] m;

  always_comb begin
    m   = msg_word(msg_idx(step_idx), stg_in.w0, word1, word2, len);
    sum = stg_in.win.q0 + round_f(step_idx, stg_in.win.q3, stg_in.win.q2, stg_in.win.q1)
          + K_TBL[step_idx] + m;
    stg_nxt.w0     = stg_in.w0;
    stg_nxt.win.q0 = stg_in.win.q1;
    stg_nxt.win.q1 = stg_in.win.q2;
    stg_nxt.win.q2 = stg_in.win.q3;
    stg_nxt.win.q3 = stg_in.win.q3 + rotl(sum, step_shift(step_idx));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stg_r <= stg_nxt;
    end
  end

  assign vld_out = vld_r;
  assign stg_out = stg_r;

endmodule
`default_nettype wire

>>> rtl/md5m_rev.sv
// md5m_rev: iterative unit undoing steps 64 down to 49, one step a cycle
// depends on md5m_pkg; holds the four check words
`timescale 1ns / 1ps
`default_nettype none
module md5m_rev import md5m_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [31:0] tgt_a,
  input  wire logic [31:0] tgt_b,
  input  wire logic [31:0] tgt_c,
  input  wire logic [31:0] tgt_d,
  input  wire logic [31:0] word1,
  input  wire logic [31:0] word2,
  input  wire logic [3:0]  len,
  output check_t           chk
);

  logic        busy_r;
  logic [3:0]  cnt_r;
  win_t        win_r;
  logic [31:0] ca_r, cb_r, cc_r, cd_r;
  logic [5:0]  t;
  logic [31:0] q_new;

  // window holds q[t+1] .. q[t+4]; step t yields q[t]
  always_comb begin
    t     = {2'b11, cnt_r};
    q_new = rotr(win_r.q3 - win_r.q2, step_shift(t))
            - msg_word(msg_idx(t), 32'd0, word1, word2, len)
            - K_TBL[t] - round_f(t, win_r.q2, win_r.q1, win_r.q0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= 4'd0;
      ca_r   <= 32'd0;
      cb_r   <= 32'd0;
      cc_r   <= 32'd0;
      cd_r   <= 32'd0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= 4'd15;
    end else if (busy_r) begin
      cnt_r <= cnt_r - 4'd1;
      if (cnt_r == 4'd0) begin
        busy_r <= 1'b0;
        ca_r   <= q_new;
        cd_r   <= win_r.q0;
        cc_r   <= win_r.q1;
        cb_r   <= win_r.q2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      win_r.q0 <= tgt_a - IV_A;
      win_r.q1 <= tgt_d - IV_D;
      win_r.q2 <= tgt_c - IV_C;
      win_r.q3 <= tgt_b - IV_B;
    end else if (busy_r) begin
      win_r <= '{q0: q_new, q1: win_r.q0, q2: win_r.q1, q3: win_r.q2};
    end
  end

  assign chk = '{busy: busy_r, a: ca_r, b: cb_r, c: cc_r, d: cd_r};

endmodule
`default_nettype wire
